// ----- rtl/klr_pkg.sv -----
package klr_pkg;

    localparam int CAPACITY  = 64;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 16;
    localparam int AMOUNT_W  = 24;
    localparam int ENTRIES_W = 7;
    localparam int TOTAL_W   = 30;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED     = 2'd0,
        ST_FULL      = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [AMOUNT_W-1:0] amount_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [TOTAL_W-1:0]  total_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;
        logic occ;
        logic shift_en;
        logic wr_en;
    } cell_ctrl_t;

endpackage

// ----- rtl/klr_if.sv -----
interface klr_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] key;
    logic [23:0] amount;

    modport source (output valid, output operation, output key, output amount, input ready);
    modport sink (input valid, input operation, input key, input amount, output ready);
endinterface

interface klr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  entries;
    logic [29:0] total;

    modport source (output valid, output status, output entries, output total, input ready);
    modport sink (input valid, input status, input entries, input total, output ready);
endinterface

// ----- rtl/keyed_list_with_running_total_unit.sv -----
// channel | dir | fields                      | beat when
// req     | in  | operation, key, amount      | req.valid & req.ready
// rsp     | out | status, entries, total      | rsp.valid & rsp.ready
//
// after accept, a request steps through key compare in every cell,
// shift/append across the cell row, then the total and count update.
// the next request is taken the cycle after the result is loaded; none is taken while one is in progress.
// reset clears count, total and control; cell contents are not cleared.
// a stalled result holds the final step until the output register frees up.
module keyed_list_with_running_total_unit
    import klr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    klr_req_if.sink          req,
    klr_rsp_if.source        rsp
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MATCH = 4'b0010,
        S_APPLY = 4'b0100,
        S_SUM   = 4'b1000
    } state_t;

    state_t  state_reg, state_next;
    logic    op_reg;
    key_t    key_reg;
    amount_t amount_reg;
    amount_t sel_amount_reg, sel_amount_next;
    logic    found_reg, found_next;
    logic    full_reg, full_next;
    count_t  count_reg, count_next;
    total_t  total_reg, total_next;

    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    logic [ENTRIES_W-1:0] entries_reg, entries_next;
    total_t  out_total_reg, out_total_next;

    key_t       cell_key    [CAPACITY];
    amount_t    cell_amount [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] below_vec;
    logic [CAPACITY-1:0] first_vec;
    cell_ctrl_t cell_ctrl   [CAPACITY];
    amount_t    match_amount;
    logic       load_out;
    logic       accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // positions below the first match, and the first match itself
    assign below_vec = (match_vec - CAPACITY'(1)) & ~match_vec;
    assign first_vec = match_vec & ~(match_vec - CAPACITY'(1));

    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        localparam count_t IDX = CNT_W'(j);
        key_t    up_key;
        amount_t up_amount;

        if (j == CAPACITY - 1)
        begin : g_last
            assign up_key    = '0;
            assign up_amount = '0;
        end
        else
        begin : g_mid
            assign up_key    = cell_key[j+1];
            assign up_amount = cell_amount[j+1];
        end

        always_comb
        begin
            cell_ctrl[j].cmp_en   = (state_reg == S_MATCH);
            cell_ctrl[j].occ      = (IDX < count_reg);
            cell_ctrl[j].shift_en = (state_reg == S_APPLY) && (op_reg == OP_REMOVE)
                                    && (|match_vec) && !below_vec[j];
            cell_ctrl[j].wr_en    = (state_reg == S_APPLY) && (op_reg == OP_ADD)
                                    && (IDX == count_reg);
        end

        klr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[j]),
            .req_key    (key_reg),
            .req_amount (amount_reg),
            .up_key     (up_key),
            .up_amount  (up_amount),
            .key        (cell_key[j]),
            .amount     (cell_amount[j]),
            .match      (match_vec[j])
        );
    end

    always_comb
    begin
        match_amount = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_amount = match_amount | (cell_amount[i] & {AMOUNT_W{first_vec[i]}});
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sel_amount_next = sel_amount_reg;
        found_next      = found_reg;
        full_next       = full_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        status_next     = status_reg;
        entries_next    = entries_reg;
        out_total_next  = out_total_reg;
        load_out        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                full_next  = (count_reg >= CNT_W'(CAPACITY));
                found_next = |match_vec;
                if (op_reg == OP_ADD)
                begin
                    sel_amount_next = amount_reg;
                end
                else
                begin
                    sel_amount_next = match_amount;
                end
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out = 1'b1;
                    if (op_reg == OP_ADD)
                    begin
                        if (full_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_ADDED;
                            count_next  = count_reg + CNT_W'(1);
                            total_next  = total_reg + TOTAL_W'(sel_amount_reg);
                        end
                    end
                    else
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_REMOVED;
                            count_next  = count_reg - CNT_W'(1);
                            total_next  = total_reg - TOTAL_W'(sel_amount_reg);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    entries_next   = ENTRIES_W'(count_next);
                    out_total_next = total_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            found_reg     <= found_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.operation;
            key_reg    <= req.key;
            amount_reg <= req.amount;
        end
        sel_amount_reg <= sel_amount_next;
        status_reg     <= status_next;
        entries_reg    <= entries_next;
        out_total_reg  <= out_total_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.entries = entries_reg;
    assign rsp.total   = out_total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) && (op_reg == OP_REMOVE) && found_reg |-> count_reg != '0)
        else $error("remove hit on an empty list");

    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) && out_valid_reg && !rsp.ready |=> state_reg == S_SUM)
        else $error("result step left while output slot busy");

    a_sum_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |=> (state_reg == S_SUM) || (state_reg == S_IDLE))
        else $error("bad exit from final step");

    a_match_onehot_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(first_vec))
        else $error("more than one first match");

endmodule

// ----- rtl/klr_cell.sv -----
module klr_cell
    import klr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  key_t       req_key,
    input  amount_t    req_amount,
    input  key_t       up_key,
    input  amount_t    up_amount,
    output key_t       key,
    output amount_t    amount,
    output logic       match
);

    key_t    key_reg;
    amount_t amount_reg;
    logic    match_reg;
    logic    match_next;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = ctrl.occ && (key_reg == req_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // append writes the request, remove pulls the upper neighbor down
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            key_reg    <= req_key;
            amount_reg <= req_amount;
        end
        else if (ctrl.shift_en)
        begin
            key_reg    <= up_key;
            amount_reg <= up_amount;
        end
    end

    assign key    = key_reg;
    assign amount = amount_reg;
    assign match  = match_reg;

endmodule

// ----- bench/klr_list_checker.sv -----
`timescale 1ns / 1ps

module klr_list_checker
    import klr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    klr_req_if   req,
    klr_rsp_if   rsp,
    output int   errors,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        status_t              status;
        logic [ENTRIES_W-1:0] entries;
        total_t               total;
    } reply_t;

    // shadow of the ordered list and its running sum
    key_t    list_key [CAPACITY];
    amount_t list_amount [CAPACITY];
    int      list_len;
    total_t  list_sum;
    reply_t  expected_replies [$];

    function automatic reply_t apply_request(logic op, key_t k, amount_t a);
        reply_t r;
        int     hit;
        hit = -1;
        if (op == OP_ADD)
        begin
            if (list_len >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                list_key[list_len]    = k;
                list_amount[list_len] = a;
                list_len++;
                list_sum = list_sum + a;
                r.status = ST_ADDED;
            end
        end
        else
        begin
            for (int i = 0; i < list_len; i++)
            begin
                if (hit < 0 && list_key[i] == k)
                    hit = i;
            end
            if (hit < 0)
            begin
                r.status = ST_NOT_FOUND;
            end
            else
            begin
                list_sum = list_sum - list_amount[hit];
                // close the gap so the remaining order is kept
                for (int j = hit; j < list_len - 1; j++)
                begin
                    list_key[j]    = list_key[j + 1];
                    list_amount[j] = list_amount[j + 1];
                end
                list_len--;
                r.status = ST_REMOVED;
            end
        end
        r.entries = ENTRIES_W'(list_len);
        r.total   = list_sum;
        return r;
    endfunction

    task automatic report(string field, longint unsigned want, longint unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            list_len = 0;
            list_sum = '0;
            expected_replies.delete();
            pending = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_replies.push_back(apply_request(req.operation, req.key, req.amount));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d",
                             $time, rsp.status, rsp.entries, rsp.total);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    checked++;
                    if (rsp.status !== want.status)
                        report("status", want.status, rsp.status);
                    if (rsp.entries !== want.entries)
                        report("entries", want.entries, rsp.entries);
                    if (rsp.total !== want.total)
                        report("total", want.total, rsp.total);
                end
            end
            pending = expected_replies.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import klr_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   checked;
    bit   quiet;
    int   n_add;
    int   n_remove;
    key_t key_pool [12];
    key_t recent_keys [$];

    klr_req_if req_ch();
    klr_rsp_if rsp_ch();

    keyed_list_with_running_total_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    klr_list_checker list_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL keyed_list_with_running_total_unit");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic amount_t pick_amount();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return amount_t'($urandom_range(0, 16777215));
        endcase
    endfunction

    function automatic key_t pick_key(logic op);
        int roll;
        roll = $urandom_range(0, 99);
        if (op == OP_REMOVE && roll < 75 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (roll < 85)
            return key_pool[$urandom_range(0, 11)];
        return key_t'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge clk);
        end
    end

    task automatic send(logic op, key_t k, amount_t a);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= k;
        req_ch.amount    <= a;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (op == OP_ADD)
        begin
            n_add++;
            recent_keys.push_back(k);
            if (recent_keys.size() > 96)
                void'(recent_keys.pop_front());
        end
        else
        begin
            n_remove++;
        end
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int   sent;
        int   phase_len;
        int   add_pct;
        logic op;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_ADD;
        req_ch.key       <= '0;
        req_ch.amount    <= '0;
        rst_n            <= 1'b0;
        foreach (key_pool[i])
            key_pool[i] = key_t'($urandom_range(0, 65535));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove from an empty list, field extremes, duplicates, first/middle/last removal
        send(OP_REMOVE, 16'h0000, 24'h000000);
        send(OP_ADD,    16'h0000, 24'h000000);
        send(OP_ADD,    16'hFFFF, 24'hFFFFFF);
        send(OP_ADD,    16'h1234, 24'h000001);
        send(OP_ADD,    16'h1234, 24'h000002);
        send(OP_ADD,    16'h8000, 24'h800000);
        send(OP_REMOVE, 16'h1234, 24'hFFFFFF);
        send(OP_REMOVE, 16'h1234, 24'h000000);
        send(OP_REMOVE, 16'h1234, 24'h000000);
        send(OP_REMOVE, 16'hFFFF, 24'h000000);
        send(OP_REMOVE, 16'h5555, 24'h000000);
        send(OP_ADD,    16'h5555, 24'h555555);
        send(OP_ADD,    16'hAAAA, 24'hAAAAAA);
        send(OP_REMOVE, 16'h0000, 24'h000000);
        send(OP_REMOVE, 16'hAAAA, 24'h000000);
        send(OP_REMOVE, 16'h8000, 24'h000000);
        send(OP_REMOVE, 16'h5555, 24'h000000);
        send(OP_REMOVE, 16'h5555, 24'h000000);
        hold_until_drained();

        // phases lean toward filling, draining or a mix so full and empty both get hit
        sent = 0;
        while (sent < 1000)
        begin
            case ($urandom_range(0, 2))
                0:       add_pct = 88;
                1:       add_pct = 15;
                default: add_pct = 50;
            endcase
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 150);
            repeat (phase_len)
            begin
                op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE;
                send(op, pick_key(op), pick_amount());
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                hold_until_drained();
        end
        quiet = 1'b0;

        hold_until_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d requests (%0d adds, %0d removes), %0d results checked",
                 n_add + n_remove, n_add, n_remove, checked);
        if (errors == 0)
            $display("PASS keyed_list_with_running_total_unit");
        else
            $display("FAIL keyed_list_with_running_total_unit");
        $finish;
    end

endmodule
